// ===== design/dtq_pkg.sv =====
package dtq_pkg;

  // Block sizing
  localparam int NUM_CLASSES  = 6;
  localparam int TIME_WIDTH   = 32;
  localparam int OTHER_FIELDS = 5;
  localparam int CHECKED_OTHERS =
    (NUM_CLASSES - 1 < OTHER_FIELDS) ? (NUM_CLASSES - 1) : OTHER_FIELDS;
  localparam int CMP_WIDTH    = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CMP_WIDTH-1:0]  cmp_t;
  typedef logic [15:0]           q15_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EVAL  = 2'd1,
    OP_ACT   = 2'd2,
    OP_DEACT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_DISABLED = 3'd1,
    RSN_COOLDOWN = 3'd2,
    RSN_CLASS    = 3'd3,
    RSN_LOW_CONF = 3'd4,
    RSN_OTHER    = 3'd5,
    RSN_STREAK   = 3'd6
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_TARGET     = 3'd1,
    CFG_MIN_CONF   = 3'd2,
    CFG_MAX_OTHER  = 3'd3,
    CFG_REQ_STREAK = 3'd4,
    CFG_COOLDOWN   = 3'd5,
    CFG_MAX_DUR    = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic        RST_ENABLE     = 1'b1;
  localparam logic [2:0]  RST_TARGET     = 3'd0;
  localparam q15_t        RST_MIN_CONF   = 16'd29491;
  localparam q15_t        RST_MAX_OTHER  = 16'd3277;
  localparam logic [7:0]  RST_REQ_STREAK = 8'd3;
  localparam logic [31:0] RST_COOLDOWN   = 32'd30000;
  localparam logic [15:0] RST_MAX_DUR    = 16'd5000;

  // Detection check settings seen by the evaluator
  typedef struct packed {
    logic       enable;
    logic [2:0] target_class;
    q15_t       min_conf;
    q15_t       max_other;
    logic [7:0] req_streak;
  } det_cfg_t;

  typedef struct packed {
    reason_t    reason;
    logic [7:0] streak;
  } eval_res_t;

endpackage

// ===== design/dtq_eval.sv =====
module dtq_eval (
  input  dtq_pkg::det_cfg_t  cfg,
  input  logic               cool_ok,
  input  logic [2:0]         class_index,
  input  dtq_pkg::q15_t      top_confidence,
  input  dtq_pkg::q15_t      other_prob [dtq_pkg::OTHER_FIELDS],
  input  logic [7:0]         streak,
  output dtq_pkg::eval_res_t res
);

  logic       other_high;
  logic [7:0] streak_inc;

  always_comb begin
    other_high = 1'b0;
    for (int i = 0; i < dtq_pkg::CHECKED_OTHERS; i++) begin
      if (other_prob[i] > cfg.max_other) other_high = 1'b1;
    end
  end

  // saturating count
  assign streak_inc = (streak == 8'hFF) ? streak : streak + 8'd1;

  always_comb begin
    res.streak = streak;
    priority if (!cfg.enable) begin
      res.reason = dtq_pkg::RSN_DISABLED;
    end else if (!cool_ok) begin
      res.reason = dtq_pkg::RSN_COOLDOWN;
    end else if (class_index != cfg.target_class) begin
      res.reason = dtq_pkg::RSN_CLASS;
      res.streak = 8'd0;
    end else if (top_confidence < cfg.min_conf) begin
      res.reason = dtq_pkg::RSN_LOW_CONF;
      res.streak = 8'd0;
    end else if (other_high) begin
      res.reason = dtq_pkg::RSN_OTHER;
      res.streak = 8'd0;
    end else begin
      res.streak = streak_inc;
      res.reason = (streak_inc < cfg.req_streak) ? dtq_pkg::RSN_STREAK : dtq_pkg::RSN_NONE;
    end
  end

endmodule

// ===== design/deterrent_trigger_qualifier.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    opcode, class, confidences, requested duration
// out_     out  out_valid/out_ready  fire_ok, reject_reason, drive_on, streak, clamped
// cfg_     in   cfg_we (no wait)     cfg_index selects register, cfg_wdata value
//
// One transaction per cycle sustained while out_ready keeps the result moving; each passes
// through the input register, then one pass of compare logic into the result register.
// The state update for a transaction happens as it moves into the result register.
// rst_n is synchronous, active low; config, state and valid registers return to their documented values.
// A stall on out_ready holds the result; the input register still takes one more.
module deterrent_trigger_qualifier (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_we,
  input  logic [dtq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtq_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [2:0]                     in_class_index,
  input  logic [15:0]                    in_top_confidence,
  input  logic [15:0]                    in_other_prob_1,
  input  logic [15:0]                    in_other_prob_2,
  input  logic [15:0]                    in_other_prob_3,
  input  logic [15:0]                    in_other_prob_4,
  input  logic [15:0]                    in_other_prob_5,
  input  logic [15:0]                    in_request_duration_ms,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_fire_ok,
  output logic [2:0]                     out_reject_reason,
  output logic                           out_drive_on,
  output logic [7:0]                     out_streak,
  output logic                           out_duration_clamped
);

  // ---------------- configuration registers ----------------
  dtq_pkg::det_cfg_t  det_cfg_r;
  logic [31:0]        cooldown_r;
  logic [15:0]        max_dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_cfg_r.enable       <= dtq_pkg::RST_ENABLE;
      det_cfg_r.target_class <= dtq_pkg::RST_TARGET;
      det_cfg_r.min_conf     <= dtq_pkg::RST_MIN_CONF;
      det_cfg_r.max_other    <= dtq_pkg::RST_MAX_OTHER;
      det_cfg_r.req_streak   <= dtq_pkg::RST_REQ_STREAK;
      cooldown_r             <= dtq_pkg::RST_COOLDOWN;
      max_dur_r              <= dtq_pkg::RST_MAX_DUR;
    end else if (cfg_we) begin
      unique case (dtq_pkg::cfg_idx_t'(cfg_index))
        dtq_pkg::CFG_ENABLE:     det_cfg_r.enable       <= cfg_wdata[0];
        dtq_pkg::CFG_TARGET:     det_cfg_r.target_class <= cfg_wdata[2:0];
        dtq_pkg::CFG_MIN_CONF:   det_cfg_r.min_conf     <= cfg_wdata[15:0];
        dtq_pkg::CFG_MAX_OTHER:  det_cfg_r.max_other    <= cfg_wdata[15:0];
        dtq_pkg::CFG_REQ_STREAK: det_cfg_r.req_streak   <= cfg_wdata[7:0];
        dtq_pkg::CFG_COOLDOWN:   cooldown_r             <= cfg_wdata[31:0];
        dtq_pkg::CFG_MAX_DUR:    max_dur_r              <= cfg_wdata[15:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                 s1_valid_r;
  dtq_pkg::op_t         s1_op_r;
  logic [2:0]           s1_class_r;
  dtq_pkg::q15_t        s1_top_r;
  dtq_pkg::q15_t        s1_other_r [dtq_pkg::OTHER_FIELDS];
  logic [15:0]          s1_req_r;

  logic out_valid_r;
  logic advance;   // result register free to take the next transaction
  logic proc;      // transaction in the input register commits this cycle
  logic in_acc;

  assign advance  = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r       <= dtq_pkg::op_t'(in_opcode);
      s1_class_r    <= in_class_index;
      s1_top_r      <= in_top_confidence;
      s1_other_r[0] <= in_other_prob_1;
      s1_other_r[1] <= in_other_prob_2;
      s1_other_r[2] <= in_other_prob_3;
      s1_other_r[3] <= in_other_prob_4;
      s1_other_r[4] <= in_other_prob_5;
      s1_req_r      <= in_request_duration_ms;
    end
  end

  // ---------------- block state ----------------
  dtq_pkg::time_t now_r, last_fire_r, drv_start_r;
  logic [15:0]    drv_len_r;
  logic           drv_active_r;
  logic [7:0]     streak_r;

  dtq_pkg::time_t now_nxt, last_fire_nxt, drv_start_nxt;
  logic [15:0]    drv_len_nxt;
  logic           drv_mid;      // drive level after the opcode, before timeout
  logic           drv_active_nxt;
  logic [7:0]     streak_nxt;
  logic           fire;
  dtq_pkg::reason_t reason;
  logic           clamped;

  dtq_pkg::time_t  since_fire, drv_elapsed;
  logic            cool_ok;
  dtq_pkg::eval_res_t ev;

  // elapsed times wrap modulo the clock width
  assign since_fire = now_r - last_fire_r;
  assign cool_ok    = !(dtq_pkg::cmp_t'(since_fire) < dtq_pkg::cmp_t'(cooldown_r));

  dtq_eval u_eval (
    .cfg            (det_cfg_r),
    .cool_ok        (cool_ok),
    .class_index    (s1_class_r),
    .top_confidence (s1_top_r),
    .other_prob     (s1_other_r),
    .streak         (streak_r),
    .res            (ev)
  );

  always_comb begin
    now_nxt       = now_r;
    last_fire_nxt = last_fire_r;
    drv_start_nxt = drv_start_r;
    drv_len_nxt   = drv_len_r;
    drv_mid       = drv_active_r;
    streak_nxt    = streak_r;
    fire          = 1'b0;
    reason        = dtq_pkg::RSN_NONE;
    clamped       = 1'b0;
    unique case (s1_op_r)
      dtq_pkg::OP_TICK: begin
        now_nxt = now_r + dtq_pkg::time_t'(1);
      end
      dtq_pkg::OP_EVAL: begin
        reason     = ev.reason;
        streak_nxt = ev.streak;
        fire       = (ev.reason == dtq_pkg::RSN_NONE);
      end
      dtq_pkg::OP_ACT: begin
        if (s1_req_r > max_dur_r) begin
          drv_len_nxt = max_dur_r;
          clamped     = 1'b1;
        end else begin
          drv_len_nxt = s1_req_r;
        end
        drv_start_nxt = now_r;
        last_fire_nxt = now_r;
        drv_mid       = 1'b1;
        streak_nxt    = 8'd0;
      end
      dtq_pkg::OP_DEACT: begin
        drv_mid = 1'b0;
      end
      default: ;
    endcase
  end

  // drive self-terminates once its length has run (zero length ends at once)
  assign drv_elapsed    = now_nxt - drv_start_nxt;
  assign drv_active_nxt = drv_mid && (drv_elapsed < dtq_pkg::time_t'(drv_len_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      last_fire_r  <= '0;
      drv_start_r  <= '0;
      drv_len_r    <= '0;
      drv_active_r <= 1'b0;
      streak_r     <= '0;
    end else if (proc) begin
      now_r        <= now_nxt;
      last_fire_r  <= last_fire_nxt;
      drv_start_r  <= drv_start_nxt;
      drv_len_r    <= drv_len_nxt;
      drv_active_r <= drv_active_nxt;
      streak_r     <= streak_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_fire_ok          <= fire;
      out_reject_reason    <= reason;
      out_drive_on         <= drv_active_nxt;
      out_streak           <= streak_nxt;
      out_duration_clamped <= clamped;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a pending transaction in the input register is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input register lost a pending transaction");

  // a stalled result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result register lost a pending transaction");

  // drive only turns on through an activate transaction
  a_drive_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(drv_active_r) |-> $past(proc && (s1_op_r == dtq_pkg::OP_ACT)))
    else $error("drive turned on without an activate");

  // a firing result carries no reason and a nonzero streak
  a_fire_cons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fire_ok |->
      (out_reject_reason == dtq_pkg::RSN_NONE) && (out_streak != 8'd0))
    else $error("inconsistent fire result");
`endif

endmodule
